### design/i2cm_pkg.sv
// Shared types, codes and constants of the I2C master transaction engine.
package i2cm_pkg;

   localparam int MAX_BYTES_DEFAULT = 16;
   localparam logic [9:0] PHASE_LEN_RESET = 10'd5;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Result tdata bit positions
   localparam int RSP_SCL    = 0;
   localparam int RSP_SDA    = 1;
   localparam int RSP_RXD_LO = 2;
   localparam int RSP_DONE   = 10;
   localparam int RSP_STATUS = 11;
   localparam int RSP_BUSY   = 12;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_BEGIN = 2'd2;

   localparam logic [1:0] K_PING  = 2'd0;
   localparam logic [1:0] K_WRITE = 2'd1;
   localparam logic [1:0] K_READ  = 2'd2;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'b000000000000001,
      ST_START_A = 15'b000000000000010,
      ST_START_B = 15'b000000000000100,
      ST_TX_SET  = 15'b000000000001000,
      ST_TX_HI   = 15'b000000000010000,
      ST_TX_LO   = 15'b000000000100000,
      ST_ACK_HI  = 15'b000000001000000,
      ST_ACK_LO  = 15'b000000010000000,
      ST_RX_HI   = 15'b000000100000000,
      ST_RX_LO   = 15'b000001000000000,
      ST_MA_SET  = 15'b000010000000000,
      ST_MA_HI   = 15'b000100000000000,
      ST_MA_LO   = 15'b001000000000000,
      ST_STOP_A  = 15'b010000000000000,
      ST_STOP_B  = 15'b100000000000000
   } step_type;

   typedef enum logic [4:0] {
      G_ADDR1 = 5'b00001,
      G_MEM   = 5'b00010,
      G_ADDR2 = 5'b00100,
      G_WDATA = 5'b01000,
      G_RDATA = 5'b10000
   } stage_type;

   // Pin levels {scl, sda} a phase drives on entry
   function automatic logic [1:0] phase_levels(step_type st, logic tx_bit, logic ack_bit);
      logic [1:0] lv;
      unique case (st)
         ST_START_A:           lv = 2'b11;
         ST_START_B:           lv = 2'b10;
         ST_TX_SET, ST_TX_LO:  lv = {1'b0, tx_bit};
         ST_TX_HI:             lv = {1'b1, tx_bit};
         ST_ACK_HI, ST_RX_HI:  lv = 2'b11;
         ST_ACK_LO, ST_RX_LO:  lv = 2'b01;
         ST_MA_SET, ST_MA_LO:  lv = {1'b0, ack_bit};
         ST_MA_HI:             lv = {1'b1, ack_bit};
         ST_STOP_A:            lv = 2'b10;
         default:              lv = 2'b11;
      endcase
      return lv;
   endfunction

endpackage

### design/i2c_master_transaction_engine.sv
// I2C master transaction engine: bus phase sequencer, write buffer and APB register.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_tvalid/req_tready   | tuser op,kind; tdata request fields
//   rsp     | out       | rsp_tvalid/rsp_tready   | tdata pins/status; tuser rx_valid; tlast
//   csr     | in        | psel/penable/pwrite     | phase_len at byte address 0
//
// One item per clock while no result is stalled: each item updates the sequencer in the cycle it is
// accepted and its result lands in the output register on the same edge.
// A new item is taken whenever the output register is empty or being drained.
// The write buffer read port is registered and follows byte_count every cycle.
// Reset is synchronous and returns the bus to idle with both lines released.
// A stalled result holds; the input side stalls only while it is held.
module i2c_master_transaction_engine #(
   parameter int MAX_BYTES = i2cm_pkg::MAX_BYTES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // dev[7:0], reg[15:8], use_reg[16], length[21:17],
   // wr_byte[29:22], sda_in[30], zero[31]
   input  logic [i2cm_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[1:0], kind[3:2]
   input  logic [i2cm_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // scl[0], sda_out[1], rx_data[9:2], done_res[10], status[11], busy_res[12], zero[15:13]
   output logic [i2cm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rx_valid[0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [i2cm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [i2cm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [i2cm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import i2cm_pkg::*;

   localparam int FW  = $clog2(MAX_BYTES + 1);
   localparam int CW  = (FW > 5) ? FW : 5;
   localparam int AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

   // request fields
   logic [1:0] op, kind;
   logic [7:0] dev_byte, reg_byte, wr_byte;
   logic       use_reg, sda_in;
   logic [4:0] length;

   assign op           = req_tuser[1:0];
   assign kind         = req_tuser[3:2];
   assign dev_byte     = req_tdata[7:0];
   assign reg_byte     = req_tdata[15:8];
   assign use_reg      = req_tdata[16];
   assign length       = req_tdata[21:17];
   assign wr_byte      = req_tdata[29:22];
   assign sda_in       = req_tdata[30];

   // state
   step_type   st_ff, st_in;
   stage_type  stage_ff, stage_in;
   logic [9:0] pc_ff, pc_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] sh_ff, sh_in;
   logic [CW-1:0] bc_ff, bc_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic       err_ff, err_in;
   logic       scl_ff, scl_in;
   logic       sda_lvl_ff, sda_lvl_in;
   logic [9:0] phase_len_ff;
   logic [1:0] rq_kind_ff;
   logic [7:0] rq_dev_ff, rq_mem_ff;
   logic       rq_use_ff;
   logic [4:0] rq_len_ff;
   logic       latch_en;

   logic [7:0] wbuf_mem [MAX_BYTES];
   logic [7:0] rd_ff;
   logic       wr_en;

   logic       out_vld_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic       out_user_ff, out_last_ff;

   logic       accept, busy, enter_en;
   logic [10:0] pc_inc, lim;
   logic [3:0]  bit_inc;
   logic [CW:0] bc_inc;
   logic [7:0]  addr_byte, rx_shift;
   logic [7:0]  rx_data;
   logic        rx_valid, rx_last, done_res, status;
   logic [1:0]  lv;
   logic        csr_wr;

   assign accept     = req_tvalid & req_tready;
   assign req_tready = ~out_vld_ff | rsp_tready;
   assign busy       = (st_ff != ST_IDLE);

   assign pc_inc   = {1'b0, pc_ff} + 11'd1;
   assign lim      = (phase_len_ff == 10'd0) ? 11'd1 : {1'b0, phase_len_ff};
   assign bit_inc  = bit_ff + 4'd1;
   assign bc_inc   = {1'b0, bc_ff} + {{CW{1'b0}}, 1'b1};
   assign rx_shift = {sh_ff[6:0], sda_in};

   always_comb begin
      addr_byte = rq_dev_ff;
      if (rq_kind_ff == K_READ && (stage_ff == G_ADDR2 || !rq_use_ff)) begin
         addr_byte[0] = 1'b1;
      end
   end

   always_comb begin
      st_in    = st_ff;
      stage_in = stage_ff;
      pc_in    = pc_ff;
      bit_in   = bit_ff;
      sh_in    = sh_ff;
      bc_in    = bc_ff;
      fill_in  = fill_ff;
      err_in   = err_ff;
      enter_en = 1'b0;
      latch_en = 1'b0;
      wr_en    = 1'b0;
      rx_data  = 8'd0;
      rx_valid = 1'b0;
      rx_last  = 1'b0;
      done_res = 1'b0;
      status   = 1'b0;
      if (accept) begin
         priority if (op == OP_LOAD && !busy) begin
            if (fill_ff < FW'(MAX_BYTES)) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + {{(FW-1){1'b0}}, 1'b1};
            end
         end else if (op == OP_BEGIN && !busy && kind <= K_READ) begin
            latch_en = 1'b1;
            bc_in    = '0;
            err_in   = 1'b0;
            stage_in = G_ADDR1;
            // nothing to put on the bus: finish at once
            if ((kind == K_READ && length == 5'd0) ||
                (kind == K_WRITE && !use_reg && fill_ff == '0)) begin
               done_res = 1'b1;
            end else begin
               st_in    = ST_START_A;
               enter_en = 1'b1;
            end
         end else if (op == OP_TICK && busy) begin
            pc_in = pc_inc[9:0];
            if (pc_inc >= lim) begin
               enter_en = 1'b1;
               unique case (st_ff)
                  ST_START_A: st_in = ST_START_B;
                  ST_START_B: begin
                     sh_in  = addr_byte;
                     bit_in = 4'd0;
                     st_in  = ST_TX_SET;
                  end
                  ST_TX_SET: st_in = ST_TX_HI;
                  ST_TX_HI:  st_in = ST_TX_LO;
                  ST_TX_LO: begin
                     sh_in  = {sh_ff[6:0], 1'b0};
                     bit_in = bit_inc;
                     st_in  = (bit_inc >= BITS_PER_BYTE) ? ST_ACK_HI : ST_TX_SET;
                  end
                  ST_ACK_HI: begin
                     if (sda_in) begin
                        err_in = 1'b1;
                     end
                     st_in = ST_ACK_LO;
                  end
                  ST_ACK_LO: begin
                     priority if (err_ff) begin
                        st_in = ST_STOP_A;
                     end else if (rq_kind_ff == K_WRITE) begin
                        priority if (stage_ff == G_ADDR1 && rq_use_ff) begin
                           stage_in = G_MEM;
                           sh_in    = rq_mem_ff;
                           bit_in   = 4'd0;
                           st_in    = ST_TX_SET;
                        end else if (bc_ff < CW'(fill_ff) && bc_ff < CW'(MAX_BYTES)) begin
                           stage_in = G_WDATA;
                           sh_in    = rd_ff;
                           bit_in   = 4'd0;
                           bc_in    = bc_inc[CW-1:0];
                           st_in    = ST_TX_SET;
                        end else begin
                           st_in = ST_STOP_A;
                        end
                     end else if (rq_kind_ff == K_READ) begin
                        priority if (stage_ff == G_ADDR1 && rq_use_ff) begin
                           stage_in = G_MEM;
                           sh_in    = rq_mem_ff;
                           bit_in   = 4'd0;
                           st_in    = ST_TX_SET;
                        end else if (stage_ff == G_MEM) begin
                           // repeated start before the read address
                           stage_in = G_ADDR2;
                           st_in    = ST_START_A;
                        end else begin
                           stage_in = G_RDATA;
                           sh_in    = 8'd0;
                           bit_in   = 4'd0;
                           st_in    = ST_RX_HI;
                        end
                     end else begin
                        st_in = ST_STOP_A;
                     end
                  end
                  ST_RX_HI: begin
                     sh_in  = rx_shift;
                     bit_in = bit_inc;
                     if (bit_inc >= BITS_PER_BYTE) begin
                        rx_valid = 1'b1;
                        rx_data  = rx_shift;
                        rx_last  = (bc_inc >= (CW+1)'(rq_len_ff));
                     end
                     st_in = ST_RX_LO;
                  end
                  ST_RX_LO: begin
                     if (bit_ff >= BITS_PER_BYTE) begin
                        bc_in = bc_inc[CW-1:0];
                        st_in = ST_MA_SET;
                     end else begin
                        st_in = ST_RX_HI;
                     end
                  end
                  ST_MA_SET: st_in = ST_MA_HI;
                  ST_MA_HI:  st_in = ST_MA_LO;
                  ST_MA_LO: begin
                     if (bc_ff >= CW'(rq_len_ff)) begin
                        st_in = ST_STOP_A;
                     end else begin
                        sh_in  = 8'd0;
                        bit_in = 4'd0;
                        st_in  = ST_RX_HI;
                     end
                  end
                  ST_STOP_A: st_in = ST_STOP_B;
                  default: begin
                     // end of stop: report and release
                     done_res = 1'b1;
                     status   = err_ff;
                     if (rq_kind_ff == K_WRITE) begin
                        fill_in = '0;
                     end
                     st_in = ST_IDLE;
                  end
               endcase
            end
         end else begin
            // ignored command: report current levels only
         end
      end
      if (enter_en) begin
         pc_in = 10'd0;
      end
   end

   assign lv = phase_levels(st_in, sh_in[7], bc_in >= CW'(rq_len_ff));

   always_comb begin
      scl_in     = scl_ff;
      sda_lvl_in = sda_lvl_ff;
      if (enter_en) begin
         scl_in     = lv[1];
         sda_lvl_in = lv[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= ST_IDLE;
         stage_ff   <= G_ADDR1;
         pc_ff      <= '0;
         bit_ff     <= '0;
         sh_ff      <= '0;
         bc_ff      <= '0;
         fill_ff    <= '0;
         err_ff     <= 1'b0;
         scl_ff     <= 1'b1;
         sda_lvl_ff <= 1'b1;
      end else begin
         st_ff      <= st_in;
         stage_ff   <= stage_in;
         pc_ff      <= pc_in;
         bit_ff     <= bit_in;
         sh_ff      <= sh_in;
         bc_ff      <= bc_in;
         fill_ff    <= fill_in;
         err_ff     <= err_in;
         scl_ff     <= scl_in;
         sda_lvl_ff <= sda_lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (latch_en) begin
         rq_kind_ff <= kind;
         rq_dev_ff  <= dev_byte;
         rq_mem_ff  <= reg_byte;
         rq_use_ff  <= use_reg;
         rq_len_ff  <= length;
      end
   end

   // write buffer; read port tracks byte_count every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wbuf_mem[fill_ff[AW-1:0]] <= wr_byte;
      end
      rd_ff <= wbuf_mem[bc_ff[AW-1:0]];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (accept) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_data_ff <= {3'b000, (st_in != ST_IDLE), status, done_res, rx_data,
                         sda_lvl_in, scl_in};
         out_user_ff <= rx_valid;
         out_last_ff <= rx_last;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   // configuration port
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_len_ff <= PHASE_LEN_RESET;
      end else if (csr_wr && !csr_paddr[2]) begin
         phase_len_ff <= csr_pwdata[9:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? '0 : {{(CSR_DATA_W-10){1'b0}}, phase_len_ff};

endmodule

### design/i2cm_checker.sv
// Port-level checks of the I2C master transaction engine, bound to the top level.
module i2cm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic [i2cm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);
   import i2cm_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // empty output register never blocks input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a completed byte leaves SCL low and SDA released, still busy
   a_rx_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tdata[RSP_SCL] && rsp_tdata[RSP_SDA]
                                  && rsp_tdata[RSP_BUSY])
      else $error("received byte with wrong bus levels");

   // finishing returns to idle with both lines released
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_DONE] |-> !rsp_tdata[RSP_BUSY] && rsp_tdata[RSP_SCL]
                                           && rsp_tdata[RSP_SDA])
      else $error("done while bus not idle");

   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[RSP_STATUS] || rsp_tlast) |->
         (rsp_tdata[RSP_DONE] || !rsp_tdata[RSP_STATUS]) && (rsp_tuser || !rsp_tlast))
      else $error("status without done or last without byte");

endmodule

bind i2c_master_transaction_engine i2cm_checker u_i2cm_checker (.*);

### test/i2c_master_transaction_engine_test.sv
// Self-checking stream testbench for the I2C master transaction engine.
`timescale 1ns / 100ps

module i2c_master_transaction_engine_test;
   import i2cm_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_PHASE_LEN = '0;
   localparam int BUF_DEPTH = MAX_BYTES_DEFAULT;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [1:0] op;
      logic [1:0] kind;
      logic [7:0] dev;
      logic [7:0] mem;
      logic       with_mem;
      logic [4:0] len;
      logic [7:0] wr_byte;
      logic       sda_in;
   } cmd_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] rx_data;
      logic       rx_valid;
      logic       rx_last;
      logic       done;
      logic       status;
      logic       busy;
   } lines_type;

   typedef struct packed {
      cmd_type   c;
      logic      typed;
      lines_type want;
   } dir_row_type;

   // {scl, sda, rx_data, rx_valid, rx_last, done, status, busy}
   localparam lines_type BUS_FREE   = {1'b1, 1'b1, 8'h00, 5'b00000};
   localparam lines_type EMPTY_DONE = {1'b1, 1'b1, 8'h00, 5'b00100};
   localparam lines_type START_HELD = {1'b1, 1'b1, 8'h00, 5'b00001};

   logic                  clock;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   i2c_master_transaction_engine i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sequencer shadow
   step_type   bus_step = ST_IDLE;
   stage_type  seq_stage = G_ADDR1;
   logic [9:0] cfg_phase_len = PHASE_LEN_RESET;
   logic [9:0] phase_cnt = '0;
   logic [3:0] bit_cnt = '0;
   logic [7:0] shifter = '0;
   logic [4:0] byte_cnt = '0;
   logic [7:0] wr_buf [BUF_DEPTH];
   logic [4:0] wr_fill = '0;
   logic [1:0] rq_kind = '0;
   logic [7:0] rq_dev = '0;
   logic [7:0] rq_mem = '0;
   logic       rq_with_mem = 1'b0;
   logic [4:0] rq_len = '0;
   logic       pin_scl = 1'b1;
   logic       pin_sda = 1'b1;
   logic       nack_seen = 1'b0;

   lines_type bus_lines_due[$];
   int     mismatches = 0;
   int     work_items = 0;
   int     gap_lim = 6;
   int     hold_left = 0;
   int     quiet_cycles = 0;

   int plan_len   [0:4] = '{1, 2, 0, 3, 1};
   int plan_gap   [0:4] = '{6, 6, 3, 6, 0};
   int plan_items [0:4] = '{400, 250, 150, 250, 150};

   function automatic void enter_phase(step_type s);
      logic ack_bit;
      ack_bit = (byte_cnt >= rq_len);
      bus_step = s;
      phase_cnt = '0;
      case (s)
         ST_START_A:          begin pin_scl = 1'b1; pin_sda = 1'b1; end
         ST_START_B:          begin pin_scl = 1'b1; pin_sda = 1'b0; end
         ST_TX_SET, ST_TX_LO: begin pin_scl = 1'b0; pin_sda = shifter[7]; end
         ST_TX_HI:            begin pin_scl = 1'b1; pin_sda = shifter[7]; end
         ST_ACK_HI, ST_RX_HI: begin pin_scl = 1'b1; pin_sda = 1'b1; end
         ST_ACK_LO, ST_RX_LO: begin pin_scl = 1'b0; pin_sda = 1'b1; end
         ST_MA_SET, ST_MA_LO: begin pin_scl = 1'b0; pin_sda = ack_bit; end
         ST_MA_HI:            begin pin_scl = 1'b1; pin_sda = ack_bit; end
         ST_STOP_A:           begin pin_scl = 1'b1; pin_sda = 1'b0; end
         default:             begin pin_scl = 1'b1; pin_sda = 1'b1; end
      endcase
   endfunction

   function automatic void load_shifter(logic [7:0] b);
      shifter = b;
      bit_cnt = '0;
      enter_phase(ST_TX_SET);
   endfunction

   // Pick the next byte or phase once the slave has answered
   function automatic void after_ack();
      if (nack_seen) begin
         enter_phase(ST_STOP_A);
         return;
      end
      if (rq_kind == K_WRITE) begin
         if (seq_stage == G_ADDR1 && rq_with_mem) begin
            seq_stage = G_MEM;
            load_shifter(rq_mem);
         end else if (byte_cnt < wr_fill && byte_cnt < BUF_DEPTH) begin
            seq_stage = G_WDATA;
            load_shifter(wr_buf[byte_cnt]);
            byte_cnt++;
         end else begin
            enter_phase(ST_STOP_A);
         end
      end else if (rq_kind == K_READ) begin
         if (seq_stage == G_ADDR1 && rq_with_mem) begin
            seq_stage = G_MEM;
            load_shifter(rq_mem);
         end else if (seq_stage == G_MEM) begin
            seq_stage = G_ADDR2;
            enter_phase(ST_START_A);
         end else begin
            seq_stage = G_RDATA;
            shifter = '0;
            bit_cnt = '0;
            enter_phase(ST_RX_HI);
         end
      end else begin
         enter_phase(ST_STOP_A);
      end
   endfunction

   function automatic lines_type next_bus_lines(cmd_type c);
      lines_type r;
      logic   was_busy;
      logic [9:0] lim;
      logic [7:0] addr;
      r = '0;
      was_busy = (bus_step != ST_IDLE);
      lim = (cfg_phase_len == 10'd0) ? 10'd1 : cfg_phase_len;
      if (c.op == OP_LOAD && !was_busy) begin
         if (wr_fill < BUF_DEPTH) begin
            wr_buf[wr_fill] = c.wr_byte;
            wr_fill++;
         end
      end else if (c.op == OP_BEGIN && !was_busy && c.kind <= K_READ) begin
         rq_kind = c.kind;
         rq_dev = c.dev;
         rq_mem = c.mem;
         rq_with_mem = c.with_mem;
         rq_len = c.len;
         byte_cnt = '0;
         nack_seen = 1'b0;
         seq_stage = G_ADDR1;
         if ((c.kind == K_READ && c.len == 5'd0) ||
             (c.kind == K_WRITE && !c.with_mem && wr_fill == 5'd0))
            r.done = 1'b1;
         else
            enter_phase(ST_START_A);
      end else if (c.op == OP_TICK && was_busy) begin
         phase_cnt++;
         if (phase_cnt >= lim) begin
            case (bus_step)
               ST_START_A: enter_phase(ST_START_B);
               ST_START_B: begin
                  addr = rq_dev;
                  // read bit goes on the address that turns the bus around
                  if (rq_kind == K_READ && (seq_stage == G_ADDR2 || !rq_with_mem))
                     addr[0] = 1'b1;
                  load_shifter(addr);
               end
               ST_TX_SET: enter_phase(ST_TX_HI);
               ST_TX_HI:  enter_phase(ST_TX_LO);
               ST_TX_LO: begin
                  shifter = {shifter[6:0], 1'b0};
                  bit_cnt++;
                  enter_phase(bit_cnt >= BITS_PER_BYTE ? ST_ACK_HI : ST_TX_SET);
               end
               ST_ACK_HI: begin
                  if (c.sda_in) nack_seen = 1'b1;
                  enter_phase(ST_ACK_LO);
               end
               ST_ACK_LO: after_ack();
               ST_RX_HI: begin
                  shifter = {shifter[6:0], c.sda_in};
                  bit_cnt++;
                  if (bit_cnt >= BITS_PER_BYTE) begin
                     r.rx_valid = 1'b1;
                     r.rx_data = shifter;
                     r.rx_last = ({1'b0, byte_cnt} + 6'd1 >= {1'b0, rq_len});
                  end
                  enter_phase(ST_RX_LO);
               end
               ST_RX_LO: begin
                  if (bit_cnt >= BITS_PER_BYTE) begin
                     byte_cnt++;
                     enter_phase(ST_MA_SET);
                  end else begin
                     enter_phase(ST_RX_HI);
                  end
               end
               ST_MA_SET: enter_phase(ST_MA_HI);
               ST_MA_HI:  enter_phase(ST_MA_LO);
               ST_MA_LO: begin
                  if (byte_cnt >= rq_len) begin
                     enter_phase(ST_STOP_A);
                  end else begin
                     shifter = '0;
                     bit_cnt = '0;
                     enter_phase(ST_RX_HI);
                  end
               end
               ST_STOP_A: enter_phase(ST_STOP_B);
               default: begin
                  r.done = 1'b1;
                  r.status = nack_seen;
                  if (rq_kind == K_WRITE) wr_fill = '0;
                  enter_phase(ST_IDLE);
               end
            endcase
         end
      end
      r.scl = pin_scl;
      r.sda = pin_sda;
      r.busy = (bus_step != ST_IDLE);
      return r;
   endfunction

   function automatic cmd_type cmd_of(logic [1:0] op, logic [1:0] kind, logic [7:0] dev,
                                      logic [7:0] mem, logic with_mem, logic [4:0] len,
                                      logic [7:0] wr_byte, logic sda_in);
      cmd_type c;
      c.op = op;
      c.kind = kind;
      c.dev = dev;
      c.mem = mem;
      c.with_mem = with_mem;
      c.len = len;
      c.wr_byte = wr_byte;
      c.sda_in = sda_in;
      return c;
   endfunction

   // Mostly ticks through a transaction; when idle, mostly buffer loads or new transactions
   function automatic cmd_type pick_cmd();
      cmd_type c;
      int   r;
      c = cmd_of(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                 1'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
      r = $urandom_range(0, 99);
      if (bus_step != ST_IDLE) begin
         if (r < 3)
            c.op = 2'($urandom_range(1, 3));
         else if (bus_step == ST_ACK_HI)
            c.sda_in = ($urandom_range(0, 15) == 0);
      end else if (r < 8) begin
         c.op = (r < 3) ? OP_TICK : (r < 6) ? OP_NONE : OP_BEGIN;
         if (c.op == OP_BEGIN) c.kind = KIND_NONE;
      end else if (r < 55) begin
         c.op = OP_LOAD;
      end else begin
         c.op = OP_BEGIN;
         r = $urandom_range(0, 99);
         c.kind = (cfg_phase_len > 10'd100) ? K_PING :
                  (r < 25) ? K_PING : (r < 65) ? K_WRITE : K_READ;
         r = $urandom_range(0, 7);
         c.len = (r == 0) ? 5'($urandom_range(17, 31)) :
                 (r == 1) ? 5'd0 : (r == 2) ? 5'd16 : 5'($urandom_range(1, 4));
      end
      return c;
   endfunction

   task automatic send_cmd(cmd_type c, logic typed, lines_type want);
      int        gap;
      logic      was_busy;
      lines_type predicted;
      gap = $urandom_range(0, gap_lim);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {1'b0, c.sda_in, c.wr_byte, c.len, c.with_mem, c.mem, c.dev};
      req_tuser <= {c.kind, c.op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      was_busy = (bus_step != ST_IDLE);
      predicted = next_bus_lines(c);
      if (was_busy ? c.op == OP_TICK
                   : (c.op == OP_LOAD || (c.op == OP_BEGIN && c.kind <= K_READ)))
         work_items++;
      bus_lines_due.push_back(typed ? want : predicted);
   endtask

   task automatic finish_pending();
      req_tvalid <= 1'b0;
      while (bus_lines_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write, or read and compare, phase_len; releases the bus before it ends
   task automatic csr_access(logic wr, logic [9:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= REG_PHASE_LEN;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (wr) begin
         cfg_phase_len = value;
      end else if (csr_prdata[9:0] !== cfg_phase_len) begin
         $error("phase_len: expected %0d, got %0d", cfg_phase_len, csr_prdata[9:0]);
         mismatches++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      lines_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bus_lines_due.size() == 0) begin
            $error("result with no item pending: tdata 0x%04h", rsp_tdata);
            mismatches++;
         end else begin
            want = bus_lines_due.pop_front();
            check_field("scl", 8'(want.scl), 8'(rsp_tdata[RSP_SCL]));
            check_field("sda_out", 8'(want.sda), 8'(rsp_tdata[RSP_SDA]));
            check_field("rx_data", want.rx_data, rsp_tdata[RSP_RXD_LO +: 8]);
            check_field("rx_valid", 8'(want.rx_valid), 8'(rsp_tuser));
            check_field("rx_last", 8'(want.rx_last), 8'(rsp_tlast));
            check_field("done_res", 8'(want.done), 8'(rsp_tdata[RSP_DONE]));
            check_field("status", 8'(want.status), 8'(rsp_tdata[RSP_STATUS]));
            check_field("busy_res", 8'(want.busy), 8'(rsp_tdata[RSP_BUSY]));
         end
         hold_left = $urandom_range(0, gap_lim);
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      dir_row_type dir_rows[$];
      int          target;
      dir_rows.push_back({cmd_of(OP_TICK, K_PING, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 1'b0),
                          1'b1, BUS_FREE});
      dir_rows.push_back({cmd_of(OP_NONE, KIND_NONE, 8'hFF, 8'hFF, 1'b1, 5'd31, 8'hFF, 1'b1),
                          1'b1, BUS_FREE});
      dir_rows.push_back({cmd_of(OP_BEGIN, KIND_NONE, 8'h55, 8'hAA, 1'b1, 5'd3, 8'h00, 1'b0),
                          1'b1, BUS_FREE});
      // zero-length read, then a write with nothing to send: both finish at once
      dir_rows.push_back({cmd_of(OP_BEGIN, K_READ, 8'hFF, 8'h00, 1'b1, 5'd0, 8'h00, 1'b0),
                          1'b1, EMPTY_DONE});
      dir_rows.push_back({cmd_of(OP_BEGIN, K_WRITE, 8'h00, 8'hFF, 1'b0, 5'd16, 8'hFF, 1'b1),
                          1'b1, EMPTY_DONE});
      // fill the buffer, the last load falls off the end
      for (int i = 0; i <= BUF_DEPTH; i++)
         dir_rows.push_back({cmd_of(OP_LOAD, K_WRITE, 8'h00, 8'h00, 1'b0, 5'd0,
                                    (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(i * 37),
                                    1'(i)), 1'b1, BUS_FREE});
      dir_rows.push_back({cmd_of(OP_BEGIN, K_PING, 8'hA0, 8'h3C, 1'b0, 5'd1, 8'h00, 1'b0),
                          1'b1, START_HELD});
      // commands while busy are dropped
      dir_rows.push_back({cmd_of(OP_LOAD, K_PING, 8'h00, 8'h00, 1'b0, 5'd0, 8'hEE, 1'b0),
                          1'b0, lines_type'(0)});
      dir_rows.push_back({cmd_of(OP_BEGIN, K_READ, 8'h42, 8'h10, 1'b1, 5'd2, 8'h00, 1'b1),
                          1'b0, lines_type'(0)});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, '0);

      foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].want);
      while (bus_step != ST_IDLE) send_cmd(pick_cmd(), 1'b0, '0);

      for (int p = 0; p <= 4; p++) begin
         finish_pending();
         csr_access(1'b1, 10'(plan_len[p]));
         csr_access(1'b0, '0);
         gap_lim = plan_gap[p];
         target = work_items + plan_items[p];
         while (work_items < target || bus_step != ST_IDLE)
            send_cmd(pick_cmd(), 1'b0, '0);
      end

      // slowest phase setting: one ping, a few ticks into its first phase
      finish_pending();
      csr_access(1'b1, 10'd1023);
      csr_access(1'b0, '0);
      gap_lim = 0;
      send_cmd(cmd_of(OP_BEGIN, K_PING, 8'($urandom), 8'h00, 1'b0, 5'd0, 8'h00, 1'b0),
               1'b0, '0);
      repeat (16)
         send_cmd(cmd_of(OP_TICK, K_PING, 8'h00, 8'h00, 1'b0, 5'd0, 8'h00, 1'b1),
                  1'b0, '0);

      finish_pending();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && bus_lines_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
